// ----- rtl/lcer_pkg.sv -----
`default_nettype none

package lcer_pkg;

    // Field widths
    localparam int COL_W = 6;
    localparam int ROW_W = 8;
    localparam int DY_W  = 8;
    localparam int ERR_W = 11;
    localparam int E2_W  = ERR_W + 1;

    // Depth of the queue between front and walker
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0]        start_x;
        logic signed [ROW_W-1:0] start_y;
        logic [COL_W-1:0]        end_x;
        logic signed [ROW_W-1:0] end_y;
        logic                    keep_smallest;
    } lcer_req_t;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [ROW_W-1:0] row_y;
        logic                    last;
    } lcer_res_t;

    // Classified line, ready for the walker
    typedef struct packed {
        logic [COL_W-1:0]        x;
        logic signed [ROW_W-1:0] y;
        logic [COL_W-1:0]        xe;
        logic signed [ROW_W-1:0] ye;
        logic [COL_W-1:0]        dx;
        logic [DY_W-1:0]         dy;
        logic                    x_inc;
        logic                    y_inc;
        logic                    keep_smallest;
        logic signed [ERR_W-1:0] err;
    } lcer_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lcer_q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } lcer_state_t;

endpackage

`default_nettype wire

// ----- rtl/lcer_front.sv -----
`default_nettype none

module lcer_front
    import lcer_pkg::*;
#(
    parameter int COLUMNS = 64
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire lcer_req_t      request,
    output logic                busy,
    input  wire lcer_q_status_t q_status,
    output logic                push,
    output lcer_job_t           job
);

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);

    logic                    valid_reg;
    logic                    valid_next;
    lcer_req_t               req_reg;
    lcer_req_t               req_in;
    logic                    accept;
    logic signed [ROW_W:0]   ydiff;
    logic [COL_W-1:0]        dx;
    logic [DY_W-1:0]         dy;

    assign busy   = valid_reg && q_status.full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_status.full;

    // Hold the request until the queue takes it
    always_comb
    begin
        valid_next = accept || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Saturate columns to the last column
    always_comb
    begin
        req_in         = request;
        req_in.start_x = (request.start_x > COL_MAX) ? COL_MAX : request.start_x;
        req_in.end_x   = (request.end_x > COL_MAX) ? COL_MAX : request.end_x;
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
        end
    end

    // Classify: distances, directions and initial error
    always_comb
    begin
        ydiff = {req_reg.end_y[ROW_W-1], req_reg.end_y}
              - {req_reg.start_y[ROW_W-1], req_reg.start_y};
        dx    = (req_reg.end_x > req_reg.start_x) ? (req_reg.end_x - req_reg.start_x)
                                                  : (req_reg.start_x - req_reg.end_x);
        dy    = (ydiff < 0) ? DY_W'(-ydiff) : DY_W'(ydiff);

        job.x             = req_reg.start_x;
        job.y             = req_reg.start_y;
        job.xe            = req_reg.end_x;
        job.ye            = req_reg.end_y;
        job.dx            = dx;
        job.dy            = dy;
        job.x_inc         = req_reg.start_x < req_reg.end_x;
        job.y_inc         = req_reg.start_y < req_reg.end_y;
        job.keep_smallest = req_reg.keep_smallest;
        job.err           = $signed({{(ERR_W-COL_W){1'b0}}, dx})
                          - $signed({{(ERR_W-DY_W){1'b0}}, dy});
    end

endmodule

`default_nettype wire

// ----- rtl/lcer_queue.sv -----
`default_nettype none

module lcer_queue
    import lcer_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lcer_job_t push_job,
    input  wire logic      pop,
    output lcer_job_t      pop_job,
    output lcer_q_status_t status
);

    lcer_job_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// ----- rtl/lcer_walk.sv -----
`default_nettype none

module lcer_walk
    import lcer_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lcer_q_status_t q_status,
    input  wire lcer_job_t      job,
    output logic                pop,
    output logic                result_valid,
    output lcer_res_t           result
);

    lcer_state_t             state_reg;
    lcer_state_t             state_next;
    lcer_job_t               job_reg;
    lcer_job_t               job_next;
    logic signed [ROW_W-1:0] kept_reg;
    logic signed [ROW_W-1:0] kept_next;
    logic                    valid_reg;
    logic                    valid_next;
    lcer_res_t               res_reg;
    lcer_res_t               res_next;

    logic signed [E2_W-1:0]  e2;
    logic                    move_x;
    logic                    move_y;
    logic                    end_after_x;
    logic [COL_W-1:0]        x1;
    logic signed [ROW_W-1:0] y1;
    logic signed [ERR_W-1:0] err1;
    logic                    better;

    assign result_valid = valid_reg;
    assign result       = res_reg;

    // One Bresenham step: x move first, y move unless the x move ended the line
    always_comb
    begin
        e2          = {job_reg.err, 1'b0};
        move_x      = e2 > -$signed({{(E2_W-DY_W){1'b0}}, job_reg.dy});
        x1          = move_x ? (job_reg.x_inc ? job_reg.x + 1'b1 : job_reg.x - 1'b1)
                             : job_reg.x;
        err1        = move_x ? job_reg.err - $signed({{(ERR_W-DY_W){1'b0}}, job_reg.dy})
                             : job_reg.err;
        end_after_x = (x1 == job_reg.xe) && (job_reg.y == job_reg.ye);
        move_y      = !end_after_x && (e2 < $signed({{(E2_W-COL_W){1'b0}}, job_reg.dx}));
        y1          = move_y ? (job_reg.y_inc ? job_reg.y + ROW_W'(1) : job_reg.y - ROW_W'(1))
                             : job_reg.y;
        better      = job_reg.keep_smallest ? (y1 < kept_reg) : (y1 > kept_reg);
    end

    // Sequence requests and emit one result per column
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        kept_next  = kept_reg;
        valid_next = 1'b0;
        res_next   = res_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    job_next  = job;
                    kept_next = job.y;
                    if ((job.x == job.xe) && (job.y == job.ye))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                job_next.x   = x1;
                job_next.y   = y1;
                job_next.err = move_y ? err1 + $signed({{(ERR_W-COL_W){1'b0}}, job_reg.dx})
                                      : err1;
                if (move_x)
                begin
                    valid_next    = 1'b1;
                    res_next.column = job_reg.x;
                    res_next.row_y  = kept_reg;
                    res_next.last   = 1'b0;
                    kept_next       = y1;
                end
                else if (better)
                begin
                    kept_next = y1;
                end
                if ((x1 == job_reg.xe) && (y1 == job_reg.ye))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                valid_next      = 1'b1;
                res_next.column = job_reg.x;
                res_next.row_y  = kept_reg;
                res_next.last   = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Hold walk position and the pending result
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        kept_reg <= kept_next;
        res_reg  <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     (valid_reg && res_reg.last) |=> !valid_reg)
        else $error("result follows the last result of a line");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_FINAL) |=> (valid_reg && res_reg.last))
        else $error("line ended without a marked result");
    assert property (@(posedge clk) disable iff (!rst_n)
                     pop |-> (state_reg == ST_IDLE))
        else $error("queue read while a line is in progress");

endmodule

`default_nettype wire

// ----- rtl/line_column_extent_rasterizer_core.sv -----
`default_nettype none

// A taken request is held in the front register, then written into the queue;
// the walker pops it only when idle. A single point goes to the final state,
// which registers its result. The walker makes one Bresenham step per cycle;
// a two-entry queue buffers requests while a line is walked.
// Results come one per cycle at most and the receiver cannot stall them.
// Reset (rst_n, asynchronous, active low) drops queued requests and any walk.
module line_column_extent_rasterizer_core
    import lcer_pkg::*;
#(
    parameter int COLUMNS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire lcer_req_t request,
    output logic           busy,
    output logic           result_valid,
    output lcer_res_t      result
);

    lcer_q_status_t q_status;
    logic           push;
    logic           pop;
    lcer_job_t      push_job;
    lcer_job_t      pop_job;

    lcer_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    lcer_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    lcer_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .job          (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
